// ===== sv/pp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp_pkg
// Shared constants, codes, types and the arctangent table of the tracker.
// ----------------------------------------------------------------------------
package pp_pkg;

   localparam int PATH_DEPTH_DEF = 1024;

   // CORDIC datapath width and step count
   localparam int CW           = 40;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = 5;

   localparam logic [27:0] GAIN_Q28         = 28'd163008218;
   localparam logic [29:0] GAIN_Q30         = 30'd652032874;
   localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;

   localparam logic [10:0] PATH_LENGTH_RST = 11'd1;
   localparam logic [30:0] LOOKAHEAD_RST   = 31'd786432;
   localparam logic [30:0] WHEEL_BASE_RST  = 31'd196608;
   localparam logic [30:0] TRAVEL_RST      = 31'd9830;

   typedef enum logic [1:0] {
      CMD_WRITE_POINT = 2'd0,
      CMD_SET_POSE    = 2'd1,
      CMD_TICK        = 2'd2,
      CMD_NONE        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_PATH_LENGTH = 2'd0,
      CSR_LOOKAHEAD   = 2'd1,
      CSR_WHEEL_BASE  = 2'd2,
      CSR_TRAVEL      = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_VECTOR = 1'b0,
      MODE_ROTATE = 1'b1
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_ctl_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] step);
      case (step)
         5'd0:  atan_turn = 32'd536870912;
         5'd1:  atan_turn = 32'd316933406;
         5'd2:  atan_turn = 32'd167458907;
         5'd3:  atan_turn = 32'd85004756;
         5'd4:  atan_turn = 32'd42667331;
         5'd5:  atan_turn = 32'd21354465;
         5'd6:  atan_turn = 32'd10679838;
         5'd7:  atan_turn = 32'd5340245;
         5'd8:  atan_turn = 32'd2670163;
         5'd9:  atan_turn = 32'd1335087;
         5'd10: atan_turn = 32'd667544;
         5'd11: atan_turn = 32'd333772;
         5'd12: atan_turn = 32'd166886;
         5'd13: atan_turn = 32'd83443;
         5'd14: atan_turn = 32'd41722;
         5'd15: atan_turn = 32'd20861;
         5'd16: atan_turn = 32'd10430;
         5'd17: atan_turn = 32'd5215;
         5'd18: atan_turn = 32'd2608;
         5'd19: atan_turn = 32'd1304;
         5'd20: atan_turn = 32'd652;
         5'd21: atan_turn = 32'd326;
         5'd22: atan_turn = 32'd163;
         5'd23: atan_turn = 32'd81;
         default: atan_turn = 32'd0;
      endcase
   endfunction

endpackage

// ===== sv/pp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp_if
// Valid/ready channels of the tracker: request, response and CSR write.
// ----------------------------------------------------------------------------
interface pp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [9:0]         point_index;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic [15:0]        heading_in;

   modport source (output valid, cmd, point_index, coord_x, coord_y, heading_in,
                   input ready);
   modport sink (input valid, cmd, point_index, coord_x, coord_y, heading_in,
                 output ready);
endinterface

interface pp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic [15:0]        pose_heading;
   logic signed [15:0] steer_angle;
   logic [9:0]         target_index;

   modport source (output valid, pose_x, pose_y, pose_heading, steer_angle,
                   target_index, input ready);
   modport sink (input valid, pose_x, pose_y, pose_heading, steer_angle,
                 target_index, output ready);
endinterface

interface pp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pp_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp_cordic
// Iterative CORDIC, vectoring or rotation, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module pp_cordic (
   input  logic                         clock,
   input  logic                         reset,
   input  pp_pkg::cordic_ctl_type       ctl,
   input  logic signed [pp_pkg::CW-1:0] x_start,
   input  logic signed [pp_pkg::CW-1:0] y_start,
   input  logic [31:0]                  ang_start,
   output logic                         done,
   output logic signed [pp_pkg::CW-1:0] x_out,
   output logic signed [pp_pkg::CW-1:0] y_out,
   output logic [31:0]                  ang_out
);
   import pp_pkg::*;

   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [33:0]   z_ff, z_in;
   logic [STEP_W-1:0]    step_ff;
   logic                 busy_ff, done_ff;
   cordic_mode_type      mode_ff;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic signed [CW-1:0] xs, ys;
   logic signed [33:0]   atan34;
   logic                 up;
   logic [31:0]          rot_ang;

   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign atan34 = $signed({2'b00, atan_turn(step_ff)});
   assign up     = (mode_ff == MODE_VECTOR) ? (y_ff > 0) : (z_ff < 0);
   assign rot_ang = ang_start + 32'h4000_0000;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (ctl.start) begin
         if (ctl.mode == MODE_VECTOR) begin
            neg_in  = 1'b0;
            zero_in = (x_start == 0) && (y_start == 0);
            if (x_start < 0) begin
               x_in = -x_start;
               y_in = -y_start;
               z_in = 34'sh0_8000_0000;
            end else begin
               x_in = x_start;
               y_in = y_start;
               z_in = '0;
            end
         end else begin
            zero_in = 1'b0;
            x_in    = $signed({(CW-30)'(0), GAIN_Q30});
            y_in    = '0;
            if (rot_ang[31]) begin
               neg_in = 1'b1;
               z_in   = 34'($signed(ang_start + 32'h8000_0000));
            end else begin
               neg_in = 1'b0;
               z_in   = 34'($signed(ang_start));
            end
         end
      end else if (busy_ff) begin
         if (up) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan34;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan34;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      if (ctl.start) begin
         mode_ff <= ctl.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign x_out   = neg_ff ? -x_ff : x_ff;
   assign y_out   = neg_ff ? -y_ff : y_ff;
   assign ang_out = zero_ff ? 32'd0 : z_ff[31:0];

endmodule

// ===== sv/pp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp_divider
// Restoring divider, 64-bit dividend by 31-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff;
   logic [30:0] rem_ff;
   logic [30:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [31:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[63]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], fits};
         rem_ff <= fits ? 31'(trial - {1'b0, div_ff}) : trial[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/pure_pursuit_path_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_path_tracker
// Pure-pursuit steering with a kinematic bicycle pose update, fixed point.
//
//   channel | dir | transaction
//   req_bus | in  | cmd, point_index, coord_x, coord_y, heading_in
//   rsp_bus | out | pose_x, pose_y, pose_heading, steer_angle, target_index
//   csr_bus | in  | index, data (always ready)
//
// Write-point, set-pose and unused commands go from idle to the reply state,
// which loads the response register and returns to idle for the next request.
// A tick scans N waypoints: each waypoint runs through the shared 24-step
// CORDIC, then three more CORDIC runs and a 64-step divide finish the step.
// Requests are taken only when idle. A stalled response holds the sequencer
// before it returns to idle.
// Reset is synchronous; the waypoint memory is not cleared.
// ----------------------------------------------------------------------------
module pure_pursuit_path_tracker #(
   parameter int PATH_DEPTH = pp_pkg::PATH_DEPTH_DEF
) (
   input logic     clock,
   input logic     reset,
   pp_req_if.sink  req_bus,
   pp_rsp_if.source rsp_bus,
   pp_csr_if.sink  csr_bus
);
   import pp_pkg::*;

   localparam int AW    = $clog2(PATH_DEPTH);
   localparam int CNT_W = $clog2(PATH_DEPTH + 1);

   typedef enum logic [22:0] {
      ST_IDLE      = 23'h000001,
      ST_SCAN_RD   = 23'h000002,
      ST_SCAN_GO   = 23'h000004,
      ST_SCAN_RUN  = 23'h000008,
      ST_MAG_LO    = 23'h000010,
      ST_MAG_HI    = 23'h000020,
      ST_MAG_CMP   = 23'h000040,
      ST_ALPHA_GO  = 23'h000080,
      ST_ALPHA_RUN = 23'h000100,
      ST_NUM_MUL   = 23'h000200,
      ST_STEER_GO  = 23'h000400,
      ST_STEER_RUN = 23'h000800,
      ST_HEAD_GO   = 23'h001000,
      ST_HEAD_RUN  = 23'h002000,
      ST_POS_X     = 23'h004000,
      ST_POS_Y     = 23'h008000,
      ST_QUO_MUL   = 23'h010000,
      ST_DIV_GO    = 23'h020000,
      ST_DIV_RUN   = 23'h040000,
      ST_INC_HI    = 23'h080000,
      ST_INC_LO    = 23'h100000,
      ST_INC_SUM   = 23'h200000,
      ST_REPLY     = 23'h400000
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < -38'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   state_type state_ff, state_in;

   // configuration
   logic [10:0] plen_ff;
   logic [30:0] look_ff, wheel_ff, travel_ff;
   logic [30:0] la;

   // pose
   logic signed [31:0] vx_ff, vy_ff;
   logic [15:0]        hd_ff;

   // waypoint memory
   logic [63:0]   wp_mem [PATH_DEPTH];
   logic [63:0]   wp_rd_ff;
   logic          wr_en;
   logic [16:0]   idx_wide;
   logic [AW-1:0] wr_addr;

   // scan
   logic [CNT_W-1:0]   i_ff, n_ff;
   logic [CNT_W-1:0]   i_next;
   logic [16:0]        n_wide;
   logic [AW-1:0]      target_ff;
   logic [35:0]        best_ff;
   logic [31:0]        best_ang_ff;
   logic [44:0]        plo_ff;
   logic [63:0]        mag_full;
   logic [35:0]        mag;
   logic signed [36:0] dsig;
   logic [35:0]        diff;
   logic signed [31:0] wp_x, wp_y;

   // tick arithmetic
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic signed [65:0] num_full;
   logic signed [65:0] rnd_full;
   logic signed [37:0] pos_sum;
   logic signed [31:0] sa_ff;
   logic [31:0]        sa_abs;
   logic signed [15:0] steer_ff;
   logic [31:0]        steer_sum;
   logic [63:0]        q_ff;
   logic [31:0]        inc_ff;
   logic [31:0]        inc_sum;
   logic [31:0]        inc_rnd;

   // shared units
   cordic_ctl_type       cord_ctl;
   logic signed [CW-1:0] cord_x0, cord_y0, cord_x, cord_y;
   logic [31:0]          cord_a0, cord_ang;
   logic                 cord_done;
   logic                 div_start, div_done;
   logic [63:0]          div_q;

   // response register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [15:0]        rsp_hd_ff;
   logic signed [15:0] rsp_steer_ff;
   logic [9:0]         rsp_target_ff;
   logic               rsp_load;

   logic    req_fire;
   cmd_type req_cmd;

   pp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cord_ctl),
      .x_start   (cord_x0),
      .y_start   (cord_y0),
      .ang_start (cord_a0),
      .done      (cord_done),
      .x_out     (cord_x),
      .y_out     (cord_y),
      .ang_out   (cord_ang)
   );

   pp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[63:0]),
      .divisor  (la),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_cmd  = cmd_type'(req_bus.cmd);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign la = (look_ff == '0) ? 31'd1 : look_ff;

   assign idx_wide = 17'(req_bus.point_index);
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_en    = req_fire && (req_cmd == CMD_WRITE_POINT) &&
                     (idx_wide < 17'(PATH_DEPTH));

   always_comb begin
      n_wide = 17'(plen_ff);
      if (n_wide == 17'd0) begin
         n_wide = 17'd1;
      end else if (n_wide > 17'(PATH_DEPTH)) begin
         n_wide = 17'(PATH_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wp_mem[wr_addr] <= {req_bus.coord_y, req_bus.coord_x};
      end
      if (state_ff == ST_SCAN_RD) begin
         wp_rd_ff <= wp_mem[i_ff[AW-1:0]];
      end
   end

   assign wp_x = $signed(wp_rd_ff[31:0]);
   assign wp_y = $signed(wp_rd_ff[63:32]);

   // magnitude and distance error
   assign mag_full = {prod_ff[46:0], 17'b0} + 64'(plo_ff);
   assign mag      = mag_full[63:28];
   assign dsig     = $signed({1'b0, mag}) - $signed({6'b0, la});
   assign diff     = dsig[36] ? 36'(-dsig) : 36'(dsig);
   assign i_next   = i_ff + 1'b1;

   assign num_full = prod_ff >>> 29;
   assign rnd_full = (prod_ff + 66'sd536870912) >>> 30;
   assign pos_sum  = 38'((state_ff == ST_POS_Y) ? vx_ff : vy_ff) +
                     $signed(rnd_full[37:0]);
   assign sa_abs   = sa_ff[31] ? 32'(-sa_ff) : 32'(sa_ff);
   assign steer_sum = cord_ang + 32'h0000_8000;
   assign inc_sum  = inc_ff + prod_ff[61:30];
   assign inc_rnd  = inc_sum + 32'h0000_8000;

   always_comb begin
      cord_ctl.start = 1'b0;
      cord_ctl.mode  = MODE_VECTOR;
      cord_x0        = CW'(CW'(wp_x) - CW'(vx_ff));
      cord_y0        = CW'(CW'(wp_y) - CW'(vy_ff));
      cord_a0        = '0;
      case (state_ff)
         ST_SCAN_GO: begin
            cord_ctl.start = 1'b1;
         end
         ST_ALPHA_GO: begin
            cord_ctl.start = 1'b1;
            cord_ctl.mode  = MODE_ROTATE;
            cord_a0        = best_ang_ff - {hd_ff, 16'b0};
         end
         ST_STEER_GO: begin
            cord_ctl.start = 1'b1;
            cord_x0        = $signed({(CW-31)'(0), la});
            cord_y0        = $signed(num_full[CW-1:0]);
         end
         ST_HEAD_GO: begin
            cord_ctl.start = 1'b1;
            cord_ctl.mode  = MODE_ROTATE;
            cord_a0        = {hd_ff, 16'b0};
         end
         default: begin
            cord_ctl.start = 1'b0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_DIV_GO);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MAG_LO: begin
            mul_a = $signed({16'b0, cord_x[16:0]});
            mul_b = $signed({5'b0, GAIN_Q28});
         end
         ST_MAG_HI: begin
            mul_a = $signed({16'b0, cord_x[33:17]});
            mul_b = $signed({5'b0, GAIN_Q28});
         end
         ST_NUM_MUL: begin
            mul_a = $signed({2'b0, wheel_ff});
            mul_b = 33'(sa_ff);
         end
         ST_POS_X: begin
            mul_a = $signed({2'b0, travel_ff});
            mul_b = cord_x[32:0];
         end
         ST_POS_Y: begin
            mul_a = $signed({2'b0, travel_ff});
            mul_b = cord_y[32:0];
         end
         ST_QUO_MUL: begin
            mul_a = $signed({2'b0, travel_ff});
            mul_b = $signed({1'b0, sa_abs});
         end
         ST_INC_HI: begin
            mul_a = $signed({1'b0, q_ff[61:30]});
            mul_b = $signed({2'b0, FOUR_OVER_PI_Q30});
         end
         ST_INC_LO: begin
            mul_a = $signed({3'b0, q_ff[29:0]});
            mul_b = $signed({2'b0, FOUR_OVER_PI_Q30});
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign rsp_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_cmd == CMD_TICK) ? ST_SCAN_RD : ST_REPLY;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_GO;
         ST_SCAN_GO:  state_in = ST_SCAN_RUN;
         ST_SCAN_RUN: begin
            if (cord_done) begin
               state_in = ST_MAG_LO;
            end
         end
         ST_MAG_LO:   state_in = ST_MAG_HI;
         ST_MAG_HI:   state_in = ST_MAG_CMP;
         ST_MAG_CMP:  state_in = (i_next == n_ff) ? ST_ALPHA_GO : ST_SCAN_RD;
         ST_ALPHA_GO: state_in = ST_ALPHA_RUN;
         ST_ALPHA_RUN: begin
            if (cord_done) begin
               state_in = ST_NUM_MUL;
            end
         end
         ST_NUM_MUL:  state_in = ST_STEER_GO;
         ST_STEER_GO: state_in = ST_STEER_RUN;
         ST_STEER_RUN: begin
            if (cord_done) begin
               state_in = ST_HEAD_GO;
            end
         end
         ST_HEAD_GO:  state_in = ST_HEAD_RUN;
         ST_HEAD_RUN: begin
            if (cord_done) begin
               state_in = ST_POS_X;
            end
         end
         ST_POS_X:    state_in = ST_POS_Y;
         ST_POS_Y:    state_in = ST_QUO_MUL;
         ST_QUO_MUL:  state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_done) begin
               state_in = ST_INC_HI;
            end
         end
         ST_INC_HI:   state_in = ST_INC_LO;
         ST_INC_LO:   state_in = ST_INC_SUM;
         ST_INC_SUM:  state_in = ST_REPLY;
         ST_REPLY: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         plen_ff      <= PATH_LENGTH_RST;
         look_ff      <= LOOKAHEAD_RST;
         wheel_ff     <= WHEEL_BASE_RST;
         travel_ff    <= TRAVEL_RST;
         vx_ff        <= '0;
         vy_ff        <= '0;
         hd_ff        <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_bus.valid) begin
            case (csr_index_type'(csr_bus.index))
               CSR_PATH_LENGTH: plen_ff   <= csr_bus.data[10:0];
               CSR_LOOKAHEAD:   look_ff   <= csr_bus.data[30:0];
               CSR_WHEEL_BASE:  wheel_ff  <= csr_bus.data[30:0];
               CSR_TRAVEL:      travel_ff <= csr_bus.data[30:0];
               default:         plen_ff   <= plen_ff;
            endcase
         end

         if (req_fire && (req_cmd == CMD_SET_POSE)) begin
            vx_ff <= req_bus.coord_x;
            vy_ff <= req_bus.coord_y;
            hd_ff <= req_bus.heading_in;
         end
         if (state_ff == ST_POS_Y) begin
            vx_ff <= sat32(pos_sum);
         end
         if (state_ff == ST_QUO_MUL) begin
            vy_ff <= sat32(pos_sum);
         end
         if ((state_ff == ST_INC_SUM) && (wheel_ff != '0)) begin
            hd_ff <= sa_ff[31] ? hd_ff - inc_rnd[31:16] : hd_ff + inc_rnd[31:16];
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         i_ff      <= '0;
         n_ff      <= CNT_W'(n_wide);
         steer_ff  <= '0;
         target_ff <= '0;
      end
      if (state_ff == ST_MAG_HI) begin
         plo_ff <= prod_ff[44:0];
      end
      if (state_ff == ST_MAG_CMP) begin
         i_ff <= i_next;
         if ((i_ff == '0) || (diff < best_ff)) begin
            best_ff     <= diff;
            best_ang_ff <= cord_ang;
            target_ff   <= i_ff[AW-1:0];
         end
      end
      if ((state_ff == ST_ALPHA_RUN) && cord_done) begin
         sa_ff <= cord_y[31:0];
      end
      if ((state_ff == ST_STEER_RUN) && cord_done) begin
         steer_ff <= $signed(steer_sum[31:16]);
      end
      if ((state_ff == ST_DIV_RUN) && div_done) begin
         q_ff <= div_q;
      end
      if (state_ff == ST_INC_LO) begin
         inc_ff <= prod_ff[31:0];
      end
      if (rsp_load) begin
         rsp_x_ff      <= vx_ff;
         rsp_y_ff      <= vy_ff;
         rsp_hd_ff     <= hd_ff;
         rsp_steer_ff  <= steer_ff;
         rsp_target_ff <= 10'(target_ff);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pose_x       = rsp_x_ff;
   assign rsp_bus.pose_y       = rsp_y_ff;
   assign rsp_bus.pose_heading = rsp_hd_ff;
   assign rsp_bus.steer_angle  = rsp_steer_ff;
   assign rsp_bus.target_index = rsp_target_ff;

endmodule

// ===== sv/pp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_steer_angle
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous transaction in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_steer_angle)))
      else $error("stalled response changed");

   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_steer_angle <= 16'sd16384) &&
                     (rsp_steer_angle >= -16'sd16384)))
      else $error("steering angle beyond a quarter turn");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind pure_pursuit_path_tracker pp_checker u_pp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_steer_angle (rsp_bus.steer_angle)
);
